[rtl/fmc_pkg.sv]
// Package for the fractionated Morse cipher: symbol codes, register indexes,
// ASCII constants, Morse tables and the decrypt symbol step.
// No dependencies.
package fmc_pkg;

    localparam int NUM_LETTERS = 26;
    localparam int KEY_W       = 5;
    localparam int CFG_DATA_W  = 60;
    localparam int KEY_TOP_W   = 10;
    localparam int MAX_RESULTS = 3;
    localparam int SEQ_LEN     = 8;

    typedef logic [1:0] t_sym;
    typedef logic [7:0] t_char;
    typedef logic [KEY_W-1:0] t_letter;

    localparam t_sym SYM_DOT  = 2'd0;
    localparam t_sym SYM_DASH = 2'd1;
    localparam t_sym SYM_SEP  = 2'd2;

    localparam logic [1:0] CFG_MODE    = 2'd0;
    localparam logic [1:0] CFG_KEY_LOW = 2'd1;
    localparam logic [1:0] CFG_KEY_MID = 2'd2;
    localparam logic [1:0] CFG_KEY_TOP = 2'd3;

    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    localparam t_char CH_UPPER_A  = 8'h41;
    localparam t_char CH_UPPER_Z  = 8'h5A;
    localparam t_char CH_LOWER_A  = 8'h61;
    localparam t_char CH_LOWER_Z  = 8'h7A;
    localparam t_char CH_SPACE    = 8'h20;
    localparam t_char CASE_OFFSET = 8'h20;

    localparam logic [2:0] MORSE_MAX = 3'd4;
    localparam logic [2:0] MORSE_OVF = 3'd5;

    // dash = 1, first symbol in the highest used bit
    localparam logic [3:0] MORSE_BITS [NUM_LETTERS] = '{
        4'd1, 4'd8, 4'd10, 4'd4, 4'd0, 4'd2, 4'd6, 4'd0, 4'd0, 4'd7, 4'd5, 4'd4, 4'd3,
        4'd2, 4'd7, 4'd6, 4'd13, 4'd2, 4'd0, 4'd1, 4'd1, 4'd1, 4'd3, 4'd9, 4'd11, 4'd12
    };
    localparam logic [2:0] MORSE_LEN [NUM_LETTERS] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
        3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
    };

    typedef struct packed {
        logic [3:0] grp;
        logic [2:0] len;
    } t_dec_st;

    typedef struct packed {
        t_dec_st st;
        logic    emit;
        t_char   ch;
    } t_dec_out;

    typedef struct packed {
        logic    hit;
        t_letter idx;
    } t_morse_hit;

    function automatic t_morse_hit morse_decode(input logic [3:0] grp, input logic [2:0] len);
        t_morse_hit r;
        r.hit = 1'b0;
        r.idx = '0;
        for (int i = NUM_LETTERS - 1; i >= 0; i--) begin
            if (MORSE_LEN[i] == len && MORSE_BITS[i] == grp) begin
                r.hit = 1'b1;
                r.idx = KEY_W'(i);
            end
        end
        return r;
    endfunction

    function automatic t_dec_out dec_step(input t_dec_st st, input t_sym s);
        t_dec_out   r;
        t_morse_hit m;
        m      = morse_decode(st.grp, st.len);
        r.st   = st;
        r.emit = 1'b0;
        r.ch   = CH_SPACE;
        if (s == SYM_SEP) begin
            if (st.len == 3'd0) begin
                r.emit = 1'b1;
            end else if (m.hit) begin
                r.emit = 1'b1;
                r.ch   = CH_UPPER_A + t_char'(m.idx);
            end
            r.st = '0;
        end else if (st.len < MORSE_MAX) begin
            r.st.grp = {st.grp[2:0], s[0]};
            r.st.len = st.len + 3'd1;
        end else begin
            r.st.len = MORSE_OVF;
        end
        return r;
    endfunction

endpackage

[rtl/fractionated_morse_cipher.sv]
// Fractionated Morse cipher, encrypt and decrypt, one character per beat.
// Depends on fmc_pkg.
//
// An accepted character lands in an input register; combinational logic turns it
// into zero to three result characters, which are loaded into a three-entry result
// buffer and sent one per cycle while the receiver is ready. A character whose
// results are done waits at most while the previous character's results drain, so
// with a ready receiver the block takes one character per cycle when each gives at
// most one result; with more, the single result port holds it back. A character
// passes the input register and then the result buffer before its first result
// beat. Configuration writes take effect at once and are meant for an idle block.
module fractionated_morse_cipher (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_idx,
    input  logic [fmc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_char_in,
    input  logic                            i_end_of_message,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [7:0]                      o_char_out,
    output logic                            o_last_of_run
);

    logic                              r_mode;
    logic [fmc_pkg::CFG_DATA_W-1:0]    r_key_low;
    logic [fmc_pkg::CFG_DATA_W-1:0]    r_key_mid;
    logic [fmc_pkg::KEY_TOP_W-1:0]     r_key_top;

    logic [3:0]                        r_pend_sym;
    logic [1:0]                        r_pend_cnt;
    fmc_pkg::t_dec_st                  r_dec;

    logic                              r_in_valid;
    fmc_pkg::t_char                    r_in_char;
    logic                              r_in_eom;

    logic [1:0]                        r_cnt;
    fmc_pkg::t_char                    r_res [fmc_pkg::MAX_RESULTS];

    logic                              out_take;
    logic                              proc_fire;

    fmc_pkg::t_letter                  key_tab [fmc_pkg::NUM_LETTERS];

    // encrypt path
    fmc_pkg::t_char                    c_up;
    logic                              is_letter;
    logic                              is_space;
    fmc_pkg::t_letter                  let_idx;
    logic [2:0]                        ml;
    logic [3:0]                        mb;
    logic [2:0]                        llen;
    fmc_pkg::t_sym                     lsym [fmc_pkg::SEQ_LEN];
    fmc_pkg::t_sym                     pend_sym [2];
    fmc_pkg::t_sym                     sym_seq [fmc_pkg::SEQ_LEN];
    logic [3:0]                        enc_len;
    logic [4:0]                        trigram [2];
    logic                              enc_v [2];
    fmc_pkg::t_char                    enc_c [2];
    logic [3:0]                        enc_base;
    logic [1:0]                        enc_rest;
    logic [3:0]                        n_pend_sym;
    logic [1:0]                        n_pend_cnt;

    // decrypt path
    logic                              dec_hit;
    fmc_pkg::t_sym                     ks [3];
    fmc_pkg::t_dec_out                 d0;
    fmc_pkg::t_dec_out                 d1;
    fmc_pkg::t_dec_out                 d2;
    fmc_pkg::t_dec_st                  dec_after;
    fmc_pkg::t_morse_hit               eom_m;
    fmc_pkg::t_dec_st                  n_dec;

    logic                              cand_v [4];
    fmc_pkg::t_char                    cand_c [4];
    logic [1:0]                        n_cnt;
    fmc_pkg::t_char                    n_res [fmc_pkg::MAX_RESULTS];

    assign out_take      = o_out_valid && i_out_ready;
    assign proc_fire     = r_in_valid && (r_cnt == 2'd0 || (r_cnt == 2'd1 && out_take));
    assign o_in_ready    = !r_in_valid || proc_fire;
    assign o_out_valid   = (r_cnt != 2'd0);
    assign o_char_out    = r_res[0];
    assign o_last_of_run = (r_cnt == 2'd1);

    always_comb begin
        for (int i = 0; i < fmc_pkg::NUM_LETTERS; i++) begin
            if (i < 12) begin
                key_tab[i] = r_key_low[fmc_pkg::KEY_W*i +: fmc_pkg::KEY_W];
            end else if (i < 24) begin
                key_tab[i] = r_key_mid[fmc_pkg::KEY_W*(i-12) +: fmc_pkg::KEY_W];
            end else begin
                key_tab[i] = r_key_top[fmc_pkg::KEY_W*(i-24) +: fmc_pkg::KEY_W];
            end
        end
    end

    always_comb begin
        c_up = r_in_char;
        if (c_up >= fmc_pkg::CH_LOWER_A && c_up <= fmc_pkg::CH_LOWER_Z) begin
            c_up = c_up - fmc_pkg::CASE_OFFSET;
        end
        is_letter = (c_up >= fmc_pkg::CH_UPPER_A) && (c_up <= fmc_pkg::CH_UPPER_Z);
        is_space  = (c_up == fmc_pkg::CH_SPACE);
        let_idx   = fmc_pkg::KEY_W'(c_up - fmc_pkg::CH_UPPER_A);
        ml        = is_letter ? fmc_pkg::MORSE_LEN[let_idx] : 3'd0;
        mb        = is_letter ? fmc_pkg::MORSE_BITS[let_idx] : 4'd0;
        llen      = is_letter ? ml + 3'd1 : (is_space ? 3'd1 : 3'd0);

        for (int i = 0; i < fmc_pkg::SEQ_LEN; i++) begin
            lsym[i] = fmc_pkg::SYM_SEP;
            if (3'(i) < ml) begin
                lsym[i] = {1'b0, mb[2'(ml - 3'(i) - 3'd1)]};
            end
        end

        pend_sym[0] = r_pend_sym[1:0];
        pend_sym[1] = r_pend_sym[3:2];
        for (int j = 0; j < fmc_pkg::SEQ_LEN; j++) begin
            if (4'(j) < 4'(r_pend_cnt)) begin
                sym_seq[j] = pend_sym[j % 2];
            end else begin
                sym_seq[j] = lsym[3'(3'(j) - 3'(r_pend_cnt))];
            end
        end
        enc_len = 4'(r_pend_cnt) + 4'(llen) + 4'(r_in_eom);

        for (int g = 0; g < 2; g++) begin
            trigram[g] = 5'(sym_seq[3*g]) * 5'd9 + 5'(sym_seq[3*g+1]) * 5'd3
                       + 5'(sym_seq[3*g+2]);
            enc_v[g]   = (enc_len >= 4'(3*(g+1))) && (trigram[g] < 5'(fmc_pkg::NUM_LETTERS));
            enc_c[g]   = enc_v[g] ? fmc_pkg::CH_UPPER_A + fmc_pkg::t_char'(key_tab[trigram[g]])
                                  : fmc_pkg::CH_UPPER_A;
        end

        if (enc_len >= 4'd6) begin
            enc_base = 4'd6;
        end else if (enc_len >= 4'd3) begin
            enc_base = 4'd3;
        end else begin
            enc_base = 4'd0;
        end
        enc_rest   = 2'(enc_len - enc_base);
        n_pend_sym = 4'd0;
        if (enc_rest >= 2'd1) begin
            n_pend_sym[1:0] = sym_seq[3'(enc_base)];
        end
        if (enc_rest >= 2'd2) begin
            n_pend_sym[3:2] = sym_seq[3'(enc_base + 4'd1)];
        end
        n_pend_cnt = enc_rest;
        if (r_in_eom) begin
            n_pend_sym = 4'd0;
            n_pend_cnt = 2'd0;
        end
    end

    always_comb begin
        dec_hit = 1'b0;
        ks[0]   = fmc_pkg::SYM_DOT;
        ks[1]   = fmc_pkg::SYM_DOT;
        ks[2]   = fmc_pkg::SYM_DOT;
        if (r_in_char >= fmc_pkg::CH_UPPER_A && r_in_char <= fmc_pkg::CH_UPPER_Z) begin
            for (int k = fmc_pkg::NUM_LETTERS - 1; k >= 0; k--) begin
                if (key_tab[k] == fmc_pkg::KEY_W'(r_in_char - fmc_pkg::CH_UPPER_A)) begin
                    dec_hit = 1'b1;
                    ks[0]   = 2'(k / 9);
                    ks[1]   = 2'((k / 3) % 3);
                    ks[2]   = 2'(k % 3);
                end
            end
        end
        d0        = fmc_pkg::dec_step(r_dec, ks[0]);
        d1        = fmc_pkg::dec_step(d0.st, ks[1]);
        d2        = fmc_pkg::dec_step(d1.st, ks[2]);
        dec_after = dec_hit ? d2.st : r_dec;
        eom_m     = fmc_pkg::morse_decode(dec_after.grp, dec_after.len);
        n_dec     = r_in_eom ? '0 : dec_after;
    end

    always_comb begin
        if (r_mode == fmc_pkg::MODE_ENCRYPT) begin
            cand_v[0] = enc_v[0];
            cand_c[0] = enc_c[0];
            cand_v[1] = enc_v[1];
            cand_c[1] = enc_c[1];
            cand_v[2] = 1'b0;
            cand_c[2] = fmc_pkg::CH_SPACE;
            cand_v[3] = 1'b0;
            cand_c[3] = fmc_pkg::CH_SPACE;
        end else begin
            cand_v[0] = dec_hit && d0.emit;
            cand_c[0] = d0.ch;
            cand_v[1] = dec_hit && d1.emit;
            cand_c[1] = d1.ch;
            cand_v[2] = dec_hit && d2.emit;
            cand_c[2] = d2.ch;
            cand_v[3] = r_in_eom && eom_m.hit;
            cand_c[3] = fmc_pkg::CH_UPPER_A + fmc_pkg::t_char'(eom_m.idx);
        end

        n_cnt = 2'd0;
        for (int i = 0; i < fmc_pkg::MAX_RESULTS; i++) begin
            n_res[i] = fmc_pkg::CH_SPACE;
        end
        for (int i = 0; i < 4; i++) begin
            if (cand_v[i] && n_cnt != 2'(fmc_pkg::MAX_RESULTS)) begin
                n_res[n_cnt] = cand_c[i];
                n_cnt        = n_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= fmc_pkg::MODE_ENCRYPT;
            r_key_low <= '0;
            r_key_mid <= '0;
            r_key_top <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fmc_pkg::CFG_MODE:    r_mode    <= i_cfg_data[0];
                fmc_pkg::CFG_KEY_LOW: r_key_low <= i_cfg_data;
                fmc_pkg::CFG_KEY_MID: r_key_mid <= i_cfg_data;
                fmc_pkg::CFG_KEY_TOP: r_key_top <= i_cfg_data[fmc_pkg::KEY_TOP_W-1:0];
                default:              r_mode    <= r_mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_sym <= '0;
            r_pend_cnt <= '0;
            r_dec      <= '0;
        end else if (proc_fire) begin
            if (r_mode == fmc_pkg::MODE_ENCRYPT) begin
                r_pend_sym <= n_pend_sym;
                r_pend_cnt <= n_pend_cnt;
            end else begin
                r_dec <= n_dec;
                if (r_in_eom) begin
                    r_pend_sym <= '0;
                    r_pend_cnt <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_char <= i_char_in;
            r_in_eom  <= i_end_of_message;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (proc_fire) begin
            r_cnt <= n_cnt;
        end else if (out_take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // advance the result buffer one beat at a time
    always_ff @(posedge i_clk) begin
        if (proc_fire) begin
            r_res <= n_res;
        end else if (out_take) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

    a_pend_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_cnt != 2'd3)
        else $error("pending symbol count out of range");

    a_morse_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dec.len <= fmc_pkg::MORSE_OVF)
        else $error("morse length out of range");

    a_eom_clears_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_fire && r_in_eom) |=> (r_pend_cnt == 2'd0))
        else $error("end of message left pending symbols");

    a_encrypt_two_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_fire && r_mode == fmc_pkg::MODE_ENCRYPT) |=> (r_cnt <= 2'd2))
        else $error("encrypt loaded more than two results");

    a_load_only_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !out_take) |=> (r_cnt == $past(r_cnt)))
        else $error("result buffer changed while stalled");

endmodule
